// ----- hdl/pom_pkg.sv -----
package pom_pkg;

	// field widths
	localparam int PowerFieldWidth = 32;
	localparam int DutyWidth       = 7;
	localparam int StepWidth       = 4;
	localparam int CfgDataWidth    = 7;

	// default power compare width
	localparam int PowerWidthDefault = 32;

	// duty limits and reset values
	localparam logic [DutyWidth-1:0] DutyMax     = 7'd100;
	localparam logic [DutyWidth-1:0] MpptReset   = 7'd20;
	localparam logic [DutyWidth-1:0] BorderReset = 7'd50;
	localparam logic [StepWidth-1:0] StepReset   = 4'd1;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_BORDER_DUTY  = 1'b0,
		REG_PERTURB_STEP = 1'b1
	} cfg_index_t;

	// duty arbitration modes
	typedef enum logic [1:0] {
		MODE_RAMP_UP = 2'd0,
		MODE_TRACK   = 2'd1,
		MODE_HOLD    = 2'd2,
		MODE_PUSH    = 2'd3
	} mode_t;

	// request payload
	typedef struct packed {
		logic signed [PowerFieldWidth-1:0] power_sample;
		logic [DutyWidth-1:0]              target_duty;
		logic [DutyWidth-1:0]              throttle_duty;
		logic [DutyWidth-1:0]              present_duty;
	} req_t;

	// result payload
	typedef struct packed {
		logic [DutyWidth-1:0] new_duty;
		logic [DutyWidth-1:0] tracked_duty;
		mode_t                mode;
	} res_t;

endpackage

// ----- hdl/perturb_observe_mppt_duty.sv -----
// Pipeline: a request accepted into the input register moves on into the result register, which drives out_valid,
// when the result register is free or drains.
// Throughput: one request per cycle while out_stall is not raised; the tracker state (duty, direction, last power)
// is a loop closed in the compute stage between input and result registers.
// Reset: arst_n clears both stages, border_duty to 50, perturb_step to 1,
// tracked duty to 20, direction to upward and last power to zero.
module perturb_observe_mppt_duty #(
	parameter int POWER_WIDTH = pom_pkg::PowerWidthDefault
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  pom_pkg::cfg_index_t                   cfg_index,
	input  logic [pom_pkg::CfgDataWidth-1:0]      cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  pom_pkg::req_t                         in_req,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output pom_pkg::res_t                         out_res
);
	import pom_pkg::*;

	logic [DutyWidth-1:0]          border_duty_q;
	logic [StepWidth-1:0]          perturb_step_q;
	logic [DutyWidth-1:0]          mppt_duty_q;
	logic                          step_down_q;
	logic signed [POWER_WIDTH-1:0] last_power_q;

	logic                          valid_s1;
	req_t                          req_s1;
	logic                          out_valid_q;
	res_t                          res_q;

	logic                          accept;
	logic                          advance;

	logic signed [POWER_WIDTH-1:0] power_w;
	logic                          dir_down;
	logic signed [DutyWidth+1:0]   stepped;
	logic [DutyWidth-1:0]          mppt_clamped;
	logic [DutyWidth-1:0]          throttle_clamped;
	logic signed [DutyWidth:0]     gap;
	logic                          target_hi;
	logic                          throttle_hi;
	res_t                          res_d;
	logic [DutyWidth-1:0]          mppt_next;

	// handshake: stage one moves on when the result register is free or drained
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && out_valid_q && out_stall;
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			border_duty_q  <= BorderReset;
			perturb_step_q <= StepReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BORDER_DUTY:  border_duty_q  <= cfg_data;
				REG_PERTURB_STEP: perturb_step_q <= cfg_data[StepWidth-1:0];
				default:          border_duty_q  <= border_duty_q;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= in_req;
		end
	end

	// power sample taken at the compare width
	generate
		if (POWER_WIDTH <= PowerFieldWidth) begin : g_power_narrow
			assign power_w = req_s1.power_sample[POWER_WIDTH-1:0];
		end else begin : g_power_wide
			assign power_w = {{(POWER_WIDTH-PowerFieldWidth){req_s1.power_sample[PowerFieldWidth-1]}},
				req_s1.power_sample};
		end
	endgenerate

	// perturb and observe step with clamp
	always_comb begin
		dir_down = (power_w > last_power_q) ? step_down_q : !step_down_q;
		if (dir_down) begin
			stepped = $signed({2'b00, mppt_duty_q}) - $signed({5'd0, perturb_step_q});
		end else begin
			stepped = $signed({2'b00, mppt_duty_q}) + $signed({5'd0, perturb_step_q});
		end
		priority if (stepped < 0) begin
			mppt_clamped = '0;
		end else if (stepped > $signed({2'b00, DutyMax})) begin
			mppt_clamped = DutyMax;
		end else begin
			mppt_clamped = stepped[DutyWidth-1:0];
		end
		throttle_clamped = (req_s1.throttle_duty > DutyMax) ? DutyMax : req_s1.throttle_duty;
	end

	// duty arbitration against the border
	always_comb begin
		target_hi   = req_s1.target_duty >= border_duty_q;
		throttle_hi = req_s1.throttle_duty >= border_duty_q;
		gap         = $signed({1'b0, border_duty_q}) - $signed({1'b0, req_s1.present_duty});
		mppt_next   = mppt_clamped;
		res_d.new_duty = req_s1.present_duty;
		unique case ({target_hi, throttle_hi})
			2'b10: begin
				res_d.mode = MODE_RAMP_UP;
				mppt_next  = throttle_clamped;
			end
			2'b11: begin
				res_d.mode     = MODE_TRACK;
				res_d.new_duty = mppt_clamped;
			end
			2'b00: begin
				res_d.mode = MODE_HOLD;
			end
			default: begin
				res_d.mode = MODE_PUSH;
				priority if (gap >= 2) begin
					res_d.new_duty = req_s1.present_duty + 7'd1;
				end else if (gap <= -2) begin
					res_d.new_duty = req_s1.present_duty - 7'd1;
				end else begin
					res_d.new_duty = req_s1.present_duty;
				end
			end
		endcase
		res_d.tracked_duty = mppt_next;
	end

	// tracker state, updated as each request commits to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mppt_duty_q  <= MpptReset;
			step_down_q  <= 1'b0;
			last_power_q <= '0;
		end else if (advance) begin
			mppt_duty_q  <= mppt_next;
			step_down_q  <= dir_down;
			last_power_q <= power_w;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	// checks
	a_tracked_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_q.tracked_duty <= DutyMax))
		else $error("tracked duty above limit");

	a_track_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.mode == MODE_TRACK) |-> (res_q.new_duty == res_q.tracked_duty))
		else $error("tracking mode duty differs from tracked duty");

	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q))
		else $error("input stalled with a free stage");

	a_state_held: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(mppt_duty_q) && $stable(step_down_q))
		else $error("tracker state moved without a committed request");

endmodule
